/* sv/nlf_pkg.sv */
// Package for the newline line framer: payload structs, command classes,
// store geometry constants and the ring index helper.
// Depends on nothing; nlf_front, nlf_back and the top level import it.
`default_nettype none

package nlf_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CAP_W       = 7;
    localparam int LEN_W       = 8;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;

    typedef enum logic [1:0] {
        OP_HEADER  = 2'd0,
        OP_BYTE    = 2'd1,
        OP_NEXT    = 2'd2,
        OP_RESTART = 2'd3
    } nlf_op_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [LEN_W-1:0]  chunk_len;
        logic [BYTE_W-1:0] data;
    } nlf_in_t;

    typedef struct packed {
        logic              status;
        logic              line_found;
        logic [BYTE_W-1:0] line_byte;
        logic              byte_valid;
        logic              last;
    } nlf_out_t;

    // Classified command as it travels through the queue.
    typedef struct packed {
        nlf_op_t           kind;
        logic [LEN_W-1:0]  arg;
        logic              arg_zero;
        logic              arg_newline;
    } nlf_cmd_t;

    typedef struct packed {
        logic     valid;
        nlf_cmd_t cmd;
    } nlf_qhead_t;

    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(STORE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(STORE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/nlf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module nlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/nlf_front.sv */
// Front end: accepts command transactions, classifies them and holds them
// in a two-entry queue for the back end. Depends on nlf_pkg.
`default_nettype none

module nlf_front
    import nlf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire nlf_in_t    request,
    output nlf_qhead_t      qhead,
    input  wire logic       pop
);

    nlf_cmd_t          q_data_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    nlf_cmd_t          cmd_in;
    logic              push;
    logic              do_pop;

    always_comb
    begin
        cmd_in.kind        = nlf_op_t'(request.op);
        cmd_in.arg         = (request.op == OP_HEADER) ? request.chunk_len : request.data;
        cmd_in.arg_zero    = (request.chunk_len == '0);
        cmd_in.arg_newline = (request.data == NEWLINE_CODE);
    end

    assign busy        = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push        = start && !busy;
    assign do_pop      = pop && (count_reg != '0);
    assign qhead.valid = (count_reg != '0);
    assign qhead.cmd   = q_data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

/* sv/nlf_back.sv */
// Back end: executes queued commands against the ring buffer and drives the
// result register. Depends on nlf_pkg and nlf_ram.
`default_nettype none

module nlf_back
    import nlf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CAP_W-1:0] capacity,
    input  wire nlf_qhead_t       qhead,
    output logic                  pop,
    output logic                  result_valid,
    output nlf_out_t              result
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } nlf_state_t;

    nlf_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]  nl_count_reg, nl_count_next;
    logic              refusing_reg, refusing_next;
    logic              open_reg, open_next;
    logic [LEN_W-1:0]  remaining_reg, remaining_next;
    logic [CNT_W-1:0]  off_reg, off_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [BYTE_W-1:0] pend_byte_reg, pend_byte_next;
    logic              res_valid_reg, res_valid_next;
    nlf_out_t          res_reg, res_next;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic [BYTE_W-1:0] rdata;
    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  space;
    logic [CNT_W-1:0]  off_inc;

    nlf_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(qhead.cmd.arg),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        if (capacity == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (capacity > CAP_W'(STORE_DEPTH))
        begin
            cap_eff = CNT_W'(STORE_DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(capacity);
        end
        space   = (held_reg < cap_eff) ? cap_eff - held_reg : '0;
        off_inc = off_reg + 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        held_next       = held_reg;
        nl_count_next   = nl_count_reg;
        refusing_next   = refusing_reg;
        open_next       = open_reg;
        remaining_next  = remaining_reg;
        off_next        = off_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        res_valid_next  = 1'b0;
        res_next        = '0;
        pop             = 1'b0;
        we              = 1'b0;
        waddr           = ring_pos(head_reg, held_reg);
        re              = 1'b0;
        raddr           = ring_pos(head_reg, off_inc);

        case (state_reg)
            ST_IDLE:
            begin
                if (qhead.valid)
                begin
                    pop = 1'b1;
                    case (qhead.cmd.kind)
                        OP_HEADER:
                        begin
                            res_valid_next = 1'b1;
                            res_next.last  = 1'b1;
                            if (refusing_reg)
                            begin
                                res_next.status = 1'b1;
                            end
                            else if (qhead.cmd.arg_zero)
                            begin
                                open_next      = 1'b0;
                                remaining_next = '0;
                            end
                            else if (qhead.cmd.arg > LEN_W'(space))
                            begin
                                refusing_next   = 1'b1;
                                open_next       = 1'b0;
                                remaining_next  = '0;
                                res_next.status = 1'b1;
                            end
                            else
                            begin
                                open_next      = 1'b1;
                                remaining_next = qhead.cmd.arg;
                            end
                        end
                        OP_BYTE:
                        begin
                            if (open_reg && (remaining_reg != '0))
                            begin
                                if (held_reg < cap_eff)
                                begin
                                    we        = 1'b1;
                                    held_next = held_reg + 1'b1;
                                    if (qhead.cmd.arg_newline)
                                    begin
                                        nl_count_next = nl_count_reg + 1'b1;
                                    end
                                end
                                remaining_next = remaining_reg - 1'b1;
                                if (remaining_reg == LEN_W'(1))
                                begin
                                    open_next = 1'b0;
                                end
                            end
                        end
                        OP_NEXT:
                        begin
                            if (refusing_reg || (nl_count_reg == '0))
                            begin
                                res_valid_next = 1'b1;
                                res_next.last  = 1'b1;
                            end
                            else
                            begin
                                re              = 1'b1;
                                raddr           = head_reg;
                                off_next        = '0;
                                pend_valid_next = 1'b0;
                                state_next      = ST_WALK;
                            end
                        end
                        OP_RESTART:
                        begin
                            head_next      = '0;
                            held_next      = '0;
                            nl_count_next  = '0;
                            refusing_next  = 1'b0;
                            open_next      = 1'b0;
                            remaining_next = '0;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (rdata == NEWLINE_CODE)
                begin
                    res_valid_next      = 1'b1;
                    res_next.line_found = 1'b1;
                    res_next.last       = 1'b1;
                    res_next.byte_valid = pend_valid_reg;
                    res_next.line_byte  = pend_valid_reg ? pend_byte_reg : '0;
                    head_next           = ring_pos(head_reg, off_inc);
                    held_next           = held_reg - off_inc;
                    nl_count_next       = nl_count_reg - 1'b1;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    re              = 1'b1;
                    off_next        = off_inc;
                    pend_byte_next  = rdata;
                    pend_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_valid_next      = 1'b1;
                        res_next.line_found = 1'b1;
                        res_next.byte_valid = 1'b1;
                        res_next.line_byte  = pend_byte_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            held_reg       <= '0;
            nl_count_reg   <= '0;
            refusing_reg   <= 1'b0;
            open_reg       <= 1'b0;
            remaining_reg  <= '0;
            off_reg        <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            held_reg       <= held_next;
            nl_count_reg   <= nl_count_next;
            refusing_reg   <= refusing_next;
            open_reg       <= open_next;
            remaining_reg  <= remaining_next;
            off_reg        <= off_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        res_reg       <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

/* sv/newline_line_framer.sv */
// Top level of the newline line framer: capacity register, front end with
// command queue, and back end with the ring buffer store.
// Depends on nlf_pkg, nlf_front, nlf_back and nlf_ram.
//
//   Channel   Handshake                    Payload
//   command   start in, busy out           request (nlf_in_t)
//   result    result_valid out, no stall   result (nlf_out_t)
//   config    cfg_valid in, cfg_ready out  cfg_data (capacity)
//
// A header, chunk byte or restart is handled in the back end's idle state;
// a header's result is registered and appears in the cycle after it leaves
// the queue. A line request walks the store byte by byte through its single
// read port; with no line it is answered from the idle state without a walk.
// The two-entry queue lets commands arrive while a line is walked; busy
// rises when it is full. Reset clears all control state; the store needs
// no clearing pass. Results are shown for one cycle and cannot be stalled.
`default_nettype none

module newline_line_framer
    import nlf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire nlf_in_t          request,
    output logic                  result_valid,
    output nlf_out_t              result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    logic [CAP_W-1:0] capacity_reg, capacity_next;
    nlf_qhead_t       qhead;
    logic             pop;

    assign cfg_ready     = 1'b1;
    assign capacity_next = (cfg_valid && cfg_ready) ? cfg_data : capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(STORE_DEPTH);
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    nlf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .qhead  (qhead),
        .pop    (pop)
    );

    nlf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity_reg),
        .qhead       (qhead),
        .pop         (pop),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule

`default_nettype wire
